FILE: rtl/ipbs_pkg.sv
// ----------------------------------------------------------------------------
// ipbs_pkg
// Shared types and constants for the integer power-by-squaring pipeline.
// ----------------------------------------------------------------------------
package ipbs_pkg;

   // Field widths of the request and response channels
   localparam int BASE_BITS     = 32;
   localparam int EXP_BITS      = 32;
   localparam int RESULT_BITS   = 32;

   // The exponent's sign bit is not scanned, so there is one step per magnitude bit
   localparam int EXP_STEP_BITS = EXP_BITS - 1;
   localparam int STEP_COUNT    = EXP_STEP_BITS;

   // Default arithmetic width of the products
   localparam int DEFAULT_WIDTH = 32;

   typedef struct packed {
      logic signed [BASE_BITS-1:0] base_value;
      logic signed [EXP_BITS-1:0]  exponent_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] power_result;
   } rsp_payload_type;

   // Control travelling down the pipeline next to the data
   typedef struct packed {
      logic                     valid;
      logic [EXP_STEP_BITS-1:0] exp_bits;
   } ipbs_ctrl_type;

endpackage

FILE: rtl/ipbs_req_if.sv
// ----------------------------------------------------------------------------
// ipbs_req_if
// Request channel: valid/ready handshake carrying a base and an exponent.
// ----------------------------------------------------------------------------
interface ipbs_req_if;
   logic                      valid;
   logic                      ready;
   ipbs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ipbs_rsp_if.sv
// ----------------------------------------------------------------------------
// ipbs_rsp_if
// Response channel: valid/ready handshake carrying the power result.
// ----------------------------------------------------------------------------
interface ipbs_rsp_if;
   logic                      valid;
   logic                      ready;
   ipbs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ipbs_step.sv
// ----------------------------------------------------------------------------
// ipbs_step
// One exponent bit: multiply the accumulator by the square when the bit is
// set, and square the square, over two register stages of split multipliers.
// ----------------------------------------------------------------------------
module ipbs_step #(
   parameter int WIDTH = ipbs_pkg::DEFAULT_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  ipbs_pkg::ipbs_ctrl_type in_ctrl,
   input  logic [WIDTH-1:0]        in_acc,
   input  logic [WIDTH-1:0]        in_sq,
   output ipbs_pkg::ipbs_ctrl_type out_ctrl,
   output logic [WIDTH-1:0]        out_acc,
   output logic [WIDTH-1:0]        out_sq
);

   localparam int LoBits = (WIDTH + 1) / 2;
   localparam int HiBits = WIDTH - LoBits;
   localparam int EB     = ipbs_pkg::EXP_STEP_BITS;

   logic [WIDTH-1:0]    mul_value;
   logic [LoBits-1:0]   acc_lo, mul_lo, sq_lo;
   logic [HiBits-1:0]   acc_hi, mul_hi, sq_hi;
   logic [2*LoBits-1:0] acc_ll_full, sq_ll_full;
   logic [WIDTH-1:0]    acc_x1_full, acc_x2_full, sq_x1_full, sq_x2_full;

   ipbs_pkg::ipbs_ctrl_type ctrl_a_in, ctrl_a_ff, ctrl_b_ff;
   logic [WIDTH-1:0]  acc_ll_ff, sq_ll_ff;
   logic [HiBits-1:0] acc_x1_ff, acc_x2_ff, sq_x1_ff, sq_x2_ff;
   logic [HiBits-1:0] acc_cross_in, sq_cross_in;
   logic [WIDTH-1:0]  acc_b_in, sq_b_in, acc_b_ff, sq_b_ff;

   // multiply by the square only where the exponent bit is set
   assign mul_value = in_ctrl.exp_bits[0] ? in_sq : {{(WIDTH-1){1'b0}}, 1'b1};

   assign acc_lo = in_acc[LoBits-1:0];
   assign acc_hi = in_acc[WIDTH-1:LoBits];
   assign mul_lo = mul_value[LoBits-1:0];
   assign mul_hi = mul_value[WIDTH-1:LoBits];
   assign sq_lo  = in_sq[LoBits-1:0];
   assign sq_hi  = in_sq[WIDTH-1:LoBits];

   // low half product; the high-by-high term falls above WIDTH bits
   assign acc_ll_full = {{LoBits{1'b0}}, acc_lo} * {{LoBits{1'b0}}, mul_lo};
   assign acc_x1_full = {{HiBits{1'b0}}, acc_lo} * {{LoBits{1'b0}}, mul_hi};
   assign acc_x2_full = {{LoBits{1'b0}}, acc_hi} * {{HiBits{1'b0}}, mul_lo};
   assign sq_ll_full  = {{LoBits{1'b0}}, sq_lo} * {{LoBits{1'b0}}, sq_lo};
   assign sq_x1_full  = {{HiBits{1'b0}}, sq_lo} * {{LoBits{1'b0}}, sq_hi};
   assign sq_x2_full  = {{LoBits{1'b0}}, sq_hi} * {{HiBits{1'b0}}, sq_lo};

   always_comb begin
      ctrl_a_in          = in_ctrl;
      ctrl_a_in.exp_bits = {1'b0, in_ctrl.exp_bits[EB-1:1]};
   end

   // combine the partial products, wrapping to WIDTH bits
   assign acc_cross_in = acc_x1_ff + acc_x2_ff;
   assign sq_cross_in  = sq_x1_ff + sq_x2_ff;
   assign acc_b_in     = acc_ll_ff + {acc_cross_in, {LoBits{1'b0}}};
   assign sq_b_in      = sq_ll_ff + {sq_cross_in, {LoBits{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff.valid <= 1'b0;
         ctrl_b_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_a_ff.valid <= ctrl_a_in.valid;
         ctrl_b_ff.valid <= ctrl_a_ff.valid;
      end
      if (advance) begin
         ctrl_a_ff.exp_bits <= ctrl_a_in.exp_bits;
         acc_ll_ff          <= acc_ll_full[WIDTH-1:0];
         acc_x1_ff          <= acc_x1_full[HiBits-1:0];
         acc_x2_ff          <= acc_x2_full[HiBits-1:0];
         sq_ll_ff           <= sq_ll_full[WIDTH-1:0];
         sq_x1_ff           <= sq_x1_full[HiBits-1:0];
         sq_x2_ff           <= sq_x2_full[HiBits-1:0];
         ctrl_b_ff.exp_bits <= ctrl_a_ff.exp_bits;
         acc_b_ff           <= acc_b_in;
         sq_b_ff            <= sq_b_in;
      end
   end

   assign out_ctrl = ctrl_b_ff;
   assign out_acc  = acc_b_ff;
   assign out_sq   = sq_b_ff;

   a_bubble_moves : assert property (@(posedge clock) disable iff (reset)
      advance && !ctrl_a_ff.valid |=> !ctrl_b_ff.valid)
      else $error("ipbs_step: bubble turned into a valid request");

   a_request_moves : assert property (@(posedge clock) disable iff (reset)
      advance && ctrl_a_ff.valid |=> ctrl_b_ff.valid)
      else $error("ipbs_step: request lost between stages");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ctrl_b_ff.valid) && $stable(acc_b_ff) && $stable(sq_b_ff))
      else $error("ipbs_step: stage changed while stalled");

endmodule

FILE: rtl/integer_power_by_squaring.sv
// ----------------------------------------------------------------------------
// integer_power_by_squaring
// Pipelined square-and-multiply: base raised to a signed exponent, products
// wrapped to WIDTH bits in two's complement.
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake     payload
//   req_chan   in         valid/ready   base_value[31:0], exponent_value[31:0]
//   rsp_chan   out        valid/ready   power_result[31:0]
//
// Each of the 31 exponent magnitude bits has its own step of two register
// stages (split partial products, then their sum).
// A new request enters every cycle while the response side takes results.
// Reset clears only the valid bits of the stages; data registers are free.
// A held response freezes every stage at once, so nothing is lost or doubled.
//
module integer_power_by_squaring #(
   parameter int WIDTH = ipbs_pkg::DEFAULT_WIDTH
) (
   input logic        clock,
   input logic        reset,
   ipbs_req_if.sink   req_chan,
   ipbs_rsp_if.source rsp_chan
);

   localparam int Steps = ipbs_pkg::STEP_COUNT;
   localparam int EB    = ipbs_pkg::EXP_STEP_BITS;
   localparam int BB    = ipbs_pkg::BASE_BITS;
   localparam int RB    = ipbs_pkg::RESULT_BITS;

   ipbs_pkg::ipbs_ctrl_type ctrl_chain [Steps+1];
   logic [WIDTH-1:0]        acc_chain  [Steps+1];
   logic [WIDTH-1:0]        sq_chain   [Steps+1];

   logic             advance;
   logic             exp_negative;
   logic [WIDTH-1:0] base_ext;
   logic [WIDTH-1:0] final_acc;

   // advance the whole pipeline unless the last stage holds an untaken result
   assign advance        = !ctrl_chain[Steps].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   assign exp_negative = req_chan.payload.exponent_value[ipbs_pkg::EXP_BITS-1];

   // widen or cut the 32-bit base to the arithmetic width
   generate
      if (WIDTH > BB) begin : g_base_wide
         assign base_ext = {{(WIDTH-BB){req_chan.payload.base_value[BB-1]}},
                            req_chan.payload.base_value};
      end else begin : g_base_narrow
         assign base_ext = req_chan.payload.base_value[WIDTH-1:0];
      end
   endgenerate

   // a negative exponent starts from zero with no bits to scan, so it drops to 0
   assign ctrl_chain[0].valid    = req_chan.valid;
   assign ctrl_chain[0].exp_bits = exp_negative ? '0
                                                : req_chan.payload.exponent_value[EB-1:0];
   assign acc_chain[0]           = {{(WIDTH-1){1'b0}}, !exp_negative};
   assign sq_chain[0]            = base_ext;

   generate
      for (genvar s = 0; s < Steps; s++) begin : g_step
         ipbs_step #(
            .WIDTH (WIDTH)
         ) u_step (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .in_ctrl  (ctrl_chain[s]),
            .in_acc   (acc_chain[s]),
            .in_sq    (sq_chain[s]),
            .out_ctrl (ctrl_chain[s+1]),
            .out_acc  (acc_chain[s+1]),
            .out_sq   (sq_chain[s+1])
         );
      end
   endgenerate

   // the last step's registers serve as the response register
   assign final_acc      = acc_chain[Steps];
   assign rsp_chan.valid = ctrl_chain[Steps].valid;

   generate
      if (WIDTH < RB) begin : g_out_extend
         assign rsp_chan.payload.power_result = {{(RB-WIDTH){final_acc[WIDTH-1]}},
                                                 final_acc};
      end else begin : g_out_cut
         assign rsp_chan.payload.power_result = final_acc[RB-1:0];
      end
   endgenerate

endmodule
